FILE: rtl/light_sample_binarizer_assert.svh
// Assertion macros shared by the light sample binarizer modules
`ifndef LIGHT_SAMPLE_BINARIZER_ASSERT_SVH
`define LIGHT_SAMPLE_BINARIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsb assertion failed");

// next-cycle implication, checked out of reset
`define LSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsb assertion failed");

`endif

FILE: rtl/lsb_pkg.sv
// Types and constants of the light sample binarizer
package lsb_pkg;

    localparam int LEVEL_W = 16;
    localparam int CNT_W   = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEVEL_W-1:0] UPPER_RESET = 16'd40000;
    localparam logic [LEVEL_W-1:0] LOWER_RESET = 16'd25000;

    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] run_len;
        logic             run_bit;
        logic             run_ovf;
        logic             own;
        logic             own_bit;
    } t_job;

endpackage

FILE: rtl/lsb_queue.sv
// Short job queue between the classifying front and the emitting back
`include "light_sample_binarizer_assert.svh"

module lsb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lsb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lsb_pkg::t_job o_job
);

    lsb_pkg::t_job                      r_mem [lsb_pkg::QUEUE_DEPTH];
    logic [lsb_pkg::QPTR_W-1:0]         r_wptr;
    logic [lsb_pkg::QPTR_W-1:0]         r_rptr;
    logic [lsb_pkg::QCNT_W-1:0]         r_count;
    logic [lsb_pkg::QCNT_W-1:0]         n_count;

    localparam logic [lsb_pkg::QCNT_W-1:0] Depth = lsb_pkg::QCNT_W'(lsb_pkg::QUEUE_DEPTH);
    localparam logic [lsb_pkg::QPTR_W-1:0] LastSlot =
        lsb_pkg::QPTR_W'(lsb_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_count == Depth);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + lsb_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - lsb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == LastSlot) ? '0 : r_wptr + lsb_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LastSlot) ? '0 : r_rptr + lsb_pkg::QPTR_W'(1);
            end
        end
    end

    `LSB_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push && !i_pop, r_count != Depth)
    `LSB_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

FILE: rtl/lsb_front.sv
// Front end: margin registers, sample classification and held-back run tracking
module lsb_front #(
    parameter int MAX_RUN = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [lsb_pkg::LEVEL_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [lsb_pkg::LEVEL_W-1:0] i_level,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output lsb_pkg::t_job               o_job
);

    localparam logic [lsb_pkg::CNT_W-1:0] MaxRun = lsb_pkg::CNT_W'(MAX_RUN);

    logic [lsb_pkg::LEVEL_W-1:0] r_upper;
    logic [lsb_pkg::LEVEL_W-1:0] r_lower;
    logic [lsb_pkg::CNT_W-1:0]   r_held;
    logic [lsb_pkg::CNT_W-1:0]   n_held;
    logic                        r_ovf;
    logic                        n_ovf;
    logic                        accept;
    logic                        is_bar;
    logic                        is_space;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_queue_full;
    assign accept      = i_in_valid && !i_queue_full;
    assign is_bar      = (i_level > r_upper);
    assign is_space    = !is_bar && (i_level < r_lower);

    always_comb begin
        n_held        = r_held;
        n_ovf         = r_ovf;
        o_push        = 1'b0;
        o_job.run_len = r_held;
        o_job.run_bit = 1'b1;
        o_job.run_ovf = r_ovf;
        o_job.own     = 1'b0;
        o_job.own_bit = 1'b0;
        if (accept) begin
            if (i_cmd == lsb_pkg::CMD_FLUSH) begin
                o_push = (r_held != '0);
                n_held = '0;
                n_ovf  = 1'b0;
            end else if (is_bar || is_space) begin
                o_push        = 1'b1;
                o_job.run_bit = is_space;
                o_job.own     = 1'b1;
                o_job.own_bit = is_bar;
                n_held        = '0;
                n_ovf         = 1'b0;
            end else if (r_held < MaxRun) begin
                n_held = r_held + lsb_pkg::CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= lsb_pkg::UPPER_RESET;
            r_lower <= lsb_pkg::LOWER_RESET;
            r_held  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_held <= n_held;
            r_ovf  <= n_ovf;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lsb_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                    lsb_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: rtl/lsb_back.sv
// Back end: expands queued jobs into result bits behind an output register
`include "light_sample_binarizer_assert.svh"

module lsb_back #(
    parameter int MAX_RUN = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lsb_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_bit_value,
    output logic          o_last,
    output logic          o_run_overflow
);

    localparam logic [lsb_pkg::CNT_W-1:0] MaxRun = lsb_pkg::CNT_W'(MAX_RUN);

    logic [lsb_pkg::CNT_W-1:0] r_rem;
    logic                      r_bit;
    logic                      r_ovf;
    logic                      r_own;
    logic                      r_own_bit;
    logic                      r_out_valid;
    logic                      r_out_bit;
    logic                      r_out_last;
    logic                      r_out_ovf;
    logic                      active;
    logic                      adv;

    assign active = (r_rem != '0) || r_own;
    assign adv    = active && (!r_out_valid || !i_out_stall);
    assign o_pop  = !active && i_q_valid;

    assign o_out_valid    = r_out_valid;
    assign o_bit_value    = r_out_bit;
    assign o_last         = r_out_last;
    assign o_run_overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_own       <= 1'b0;
            r_out_valid <= 1'b0;
            r_bit       <= 1'b0;
            r_ovf       <= 1'b0;
            r_own_bit   <= 1'b0;
            r_out_bit   <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rem     <= i_job.run_len;
                r_bit     <= i_job.run_bit;
                r_ovf     <= i_job.run_ovf;
                r_own     <= i_job.own;
                r_own_bit <= i_job.own_bit;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                if (r_rem != '0) begin
                    r_out_bit  <= r_bit;
                    r_out_last <= (r_rem == lsb_pkg::CNT_W'(1)) && !r_own;
                    r_out_ovf  <= r_ovf;
                    r_rem      <= r_rem - lsb_pkg::CNT_W'(1);
                end else begin
                    r_out_bit  <= r_own_bit;
                    r_out_last <= 1'b1;
                    r_out_ovf  <= 1'b0;
                    r_own      <= 1'b0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `LSB_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, r_rem != '0, r_rem <= MaxRun)
    `LSB_ASSERT_NEXT(a_pop_loads_work, i_clk, i_rst_n, o_pop, active)
    `LSB_ASSERT_NEXT(a_run_end_idle, i_clk, i_rst_n,
        adv && (r_rem == lsb_pkg::CNT_W'(1)) && !r_own, !active && r_out_last)

endmodule

FILE: rtl/light_sample_binarizer.sv
// Top level of the light sample binarizer: front, job queue and back
//
//   channel  direction  handshake                  payload
//   cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in       in         i_in_valid / o_in_stall    i_cmd, i_level
//   out      out        o_out_valid / i_out_stall  o_bit_value, o_last, o_run_overflow
//
// The front classifies one request per cycle while the job queue is not full; an in-between
// level only updates the held run count or its overflow flag. The back loads a job only when
// idle, then emits the held run bits and, for a certain sample, its own bit as results.
// o_in_stall rises only while the four-entry job queue is full; i_out_stall holds the output.
// Synchronous active-low reset clears counts, queue and output valid; margins return to defaults.
module light_sample_binarizer #(
    parameter int MAX_RUN = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [lsb_pkg::LEVEL_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [lsb_pkg::LEVEL_W-1:0] i_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_bit_value,
    output logic                        o_last,
    output logic                        o_run_overflow
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    lsb_pkg::t_job push_job;
    lsb_pkg::t_job pop_job;

    lsb_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_level      (i_level),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    lsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    lsb_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bit_value    (o_bit_value),
        .o_last         (o_last),
        .o_run_overflow (o_run_overflow)
    );

endmodule
